// ----- src/trapezoid_membership_min_eval_assert.svh -----
// Assertion macros used by the checker file.
`ifndef TRAPEZOID_MEMBERSHIP_MIN_EVAL_ASSERT_SVH
`define TRAPEZOID_MEMBERSHIP_MIN_EVAL_ASSERT_SVH

// Check a property outside reset.
`define TMME_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tmme assertion failed");

// Check a property at every edge, reset included.
`define TMME_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("tmme assertion failed");

`endif

// ----- src/tmme_pkg.sv -----
package tmme_pkg;

  localparam int unsigned RESOURCES = 4;
  localparam int unsigned POINTS    = 6;
  localparam int unsigned QW        = 14;
  localparam int unsigned LANE_LAT  = QW + 2;

  localparam logic        REQ_EVAL  = 1'b0;
  localparam logic        REQ_WRITE = 1'b1;

  localparam int unsigned PT_O1 = 0;
  localparam int unsigned PT_Z1 = 1;
  localparam int unsigned PT_I1 = 2;
  localparam int unsigned PT_I2 = 3;
  localparam int unsigned PT_Z2 = 4;
  localparam int unsigned PT_O2 = 5;

  localparam logic signed [15:0] Q_ONE     = 16'sd16384;
  localparam logic signed [15:0] Q_NEG_ONE = -16'sd16384;

  typedef logic signed [15:0] val_t;
  typedef val_t [POINTS-1:0] bp_set_t;
  typedef val_t [RESOURCES-1:0] lane_val_t;

  typedef struct packed {
    logic [16:0] num;
    logic [16:0] den;
    val_t        base;
  } seg_t;

endpackage

// ----- src/tmme_ram.sv -----
module tmme_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/tmme_lane.sv -----
module tmme_lane (
  input  logic             clk_i,
  input  logic             en_i,
  input  tmme_pkg::val_t   v_i,
  input  tmme_pkg::bp_set_t bp_i,
  output tmme_pkg::val_t   resp_o
);
  import tmme_pkg::*;

  seg_t        seg_d;
  seg_t        seg_q;
  logic [16:0] rem_q  [QW];
  logic [QW-1:0] quo_q [QW];
  logic [16:0] den_q  [QW];
  val_t        base_q [QW];
  val_t        resp_q;

  function automatic logic [16:0] diff(input val_t a, input val_t b);
    logic signed [16:0] d;
    d = {a[15], a} - {b[15], b};
    return d;
  endfunction

  always_comb begin
    seg_d.num  = '0;
    seg_d.den  = 17'd1;
    seg_d.base = Q_NEG_ONE;
    if (v_i < bp_i[PT_O1]) begin
      seg_d.base = Q_NEG_ONE;
    end else if (v_i < bp_i[PT_Z1]) begin
      seg_d.num  = diff(v_i, bp_i[PT_O1]);
      seg_d.den  = diff(bp_i[PT_Z1], bp_i[PT_O1]);
      seg_d.base = Q_NEG_ONE;
    end else if (v_i < bp_i[PT_I1]) begin
      seg_d.num  = diff(v_i, bp_i[PT_Z1]);
      seg_d.den  = diff(bp_i[PT_I1], bp_i[PT_Z1]);
      seg_d.base = '0;
    end else if (v_i < bp_i[PT_I2]) begin
      seg_d.base = Q_ONE;
    end else if (v_i < bp_i[PT_Z2]) begin
      seg_d.num  = diff(bp_i[PT_Z2], v_i);
      seg_d.den  = diff(bp_i[PT_Z2], bp_i[PT_I2]);
      seg_d.base = '0;
    end else if (v_i < bp_i[PT_O2]) begin
      seg_d.num  = diff(bp_i[PT_O2], v_i);
      seg_d.den  = diff(bp_i[PT_O2], bp_i[PT_Z2]);
      seg_d.base = Q_NEG_ONE;
    end
    // fold a full-scale fraction into the base
    if (seg_d.num == seg_d.den) begin
      seg_d.num  = '0;
      seg_d.base = val_t'(seg_d.base + Q_ONE);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      seg_q <= seg_d;
    end
  end

  // restoring divide, one quotient bit per stage
  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [16:0]   rem_in;
    logic [QW-1:0] quo_in;
    logic [16:0]   den_in;
    val_t          base_in;
    logic [17:0]   rem2;
    logic          take;
    if (k == 0) begin : g_first
      assign rem_in  = seg_q.num;
      assign quo_in  = '0;
      assign den_in  = seg_q.den;
      assign base_in = seg_q.base;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign quo_in  = quo_q[k-1];
      assign den_in  = den_q[k-1];
      assign base_in = base_q[k-1];
    end
    assign rem2 = {rem_in, 1'b0};
    assign take = rem2 >= {1'b0, den_in};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= take ? 17'(rem2 - {1'b0, den_in}) : rem2[16:0];
        quo_q[k]  <= {quo_in[QW-2:0], take};
        den_q[k]  <= den_in;
        base_q[k] <= base_in;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      resp_q <= 16'({base_q[QW-1][15], base_q[QW-1]} + {3'b000, quo_q[QW-1]});
    end
  end

  assign resp_o = resp_q;

endmodule

// ----- src/tmme_merge.sv -----
module tmme_merge (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic                oor_i,
  input  tmme_pkg::lane_val_t resp_i,
  output logic                valid_o,
  output tmme_pkg::val_t      value_o
);
  import tmme_pkg::*;

  val_t min_d;
  logic valid_q;
  val_t value_q;

  always_comb begin
    min_d = Q_ONE;
    for (int r = 0; r < RESOURCES; r++) begin
      if (resp_i[r] < min_d) begin
        min_d = resp_i[r];
      end
    end
    if (oor_i) begin
      min_d = Q_NEG_ONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      value_q <= min_d;
    end
  end

  assign valid_o = valid_q;
  assign value_o = value_q;

endmodule

// ----- src/trapezoid_membership_min_eval.sv -----
// Channel   Dir  tdata fields (low bit up)                                tuser
// s_axis    in   species, sunlight, moisture, temperature, incline,       req_type
//                table_resource, table_point, table_value
// m_axis    out  viability_value                                          -
//
// One request accepted per cycle while the output is not stalled; a write
// request loads one breakpoint and gives no result. An evaluate result passes
// through table read, segment select, 14-stage divider per lane, response, min merge.
// Reset clears the pipeline valid bits only; the breakpoint table is not cleared.
// A stalled result stalls the whole pipeline and input together.
module trapezoid_membership_min_eval #(
  parameter int unsigned SPECIES_COUNT = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // species[5:0] sunlight[21:6] moisture[37:22] temperature[53:38]
  // incline[69:54] table_resource[71:70] table_point[74:72] table_value[90:75]
  input  logic [95:0] s_axis_tdata,
  // req_type[0]
  input  logic [0:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // viability_value[15:0]
  output logic [15:0] m_axis_tdata
);
  import tmme_pkg::*;

  localparam int unsigned AW = (SPECIES_COUNT > 1) ? $clog2(SPECIES_COUNT) : 1;

  logic        en;
  logic        accept;
  logic        out_valid;
  logic [5:0]  species;
  logic [1:0]  tbl_res;
  logic [2:0]  tbl_pt;
  val_t        tbl_val;
  lane_val_t   vals;
  logic        in_range;
  logic [AW-1:0] addr;
  bp_set_t     bp [RESOURCES];
  lane_val_t   v1_q;
  lane_val_t   resp;
  logic        vld1_q;
  logic        oor1_q;
  logic        vld_q [LANE_LAT];
  logic        oor_q [LANE_LAT];
  val_t        out_value;

  assign en            = !out_valid || m_axis_tready;
  assign s_axis_tready = en;
  assign accept        = s_axis_tvalid && en;

  assign species  = s_axis_tdata[5:0];
  assign vals[0]  = s_axis_tdata[21:6];
  assign vals[1]  = s_axis_tdata[37:22];
  assign vals[2]  = s_axis_tdata[53:38];
  assign vals[3]  = s_axis_tdata[69:54];
  assign tbl_res  = s_axis_tdata[71:70];
  assign tbl_pt   = s_axis_tdata[74:72];
  assign tbl_val  = s_axis_tdata[90:75];
  assign in_range = 32'(species) < SPECIES_COUNT;
  assign addr     = AW'(species);

  for (genvar r = 0; r < RESOURCES; r++) begin : g_res
    for (genvar p = 0; p < POINTS; p++) begin : g_pt
      logic we;
      assign we = accept && (s_axis_tuser[0] == REQ_WRITE) && in_range &&
                  (tbl_res == 2'(r)) && (tbl_pt == 3'(p));
      tmme_ram #(
        .WIDTH(16),
        .DEPTH(SPECIES_COUNT)
      ) u_ram (
        .clk_i  (clk_i),
        .we_i   (we),
        .waddr_i(addr),
        .wdata_i(tbl_val),
        .re_i   (en),
        .raddr_i(addr),
        .rdata_o(bp[r][p])
      );
    end
    tmme_lane u_lane (
      .clk_i (clk_i),
      .en_i  (en),
      .v_i   (v1_q[r]),
      .bp_i  (bp[r]),
      .resp_o(resp[r])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      v1_q   <= vals;
      oor1_q <= !in_range;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      for (int i = 0; i < LANE_LAT; i++) begin
        vld_q[i] <= 1'b0;
      end
    end else if (en) begin
      vld1_q   <= accept && (s_axis_tuser[0] == REQ_EVAL);
      vld_q[0] <= vld1_q;
      for (int i = 1; i < LANE_LAT; i++) begin
        vld_q[i] <= vld_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      oor_q[0] <= oor1_q;
      for (int i = 1; i < LANE_LAT; i++) begin
        oor_q[i] <= oor_q[i-1];
      end
    end
  end

  tmme_merge u_merge (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(vld_q[LANE_LAT-1]),
    .oor_i  (oor_q[LANE_LAT-1]),
    .resp_i (resp),
    .valid_o(out_valid),
    .value_o(out_value)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_value;

endmodule

// ----- src/tmme_checker.sv -----
`include "trapezoid_membership_min_eval_assert.svh"

module tmme_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [95:0] s_axis_tdata,
  input logic [0:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  `TMME_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
  `TMME_ASSERT(a_out_stable, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
  `TMME_ASSERT(a_range, clk_i, rst_ni, m_axis_tvalid |-> ($signed(m_axis_tdata) >= -16'sd16384 && $signed(m_axis_tdata) <= 16'sd16384))
  `TMME_ASSERT_ALWAYS(a_ready_empty, clk_i, !m_axis_tvalid |-> s_axis_tready)

endmodule

bind trapezoid_membership_min_eval tmme_checker u_tmme_checker (.*);
